// File: rtl/tpsf_pkg.sv
// tpsf_pkg: shared sizing helper for the two-point similarity fit
// no dependencies; used by the divider and the top level
`default_nettype none
package tpsf_pkg;

    // width of the divider remainder path for a given coordinate width
    function automatic int rem_w(input int w);
        rem_w = 3 * w + 3;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tpsf_if.sv
// tpsf_pts_if and tpsf_fit_if: valid/ready channels of the similarity fit
// no dependencies
`default_nettype none
interface tpsf_pts_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] user1_x;
    logic signed [W-1:0] user1_y;
    logic signed [W-1:0] user2_x;
    logic signed [W-1:0] user2_y;
    logic signed [W-1:0] robot1_x;
    logic signed [W-1:0] robot1_y;
    logic signed [W-1:0] robot2_x;
    logic signed [W-1:0] robot2_y;

    modport source (output valid, user1_x, user1_y, user2_x, user2_y,
                    robot1_x, robot1_y, robot2_x, robot2_y, input ready);
    modport sink   (input valid, user1_x, user1_y, user2_x, user2_y,
                    robot1_x, robot1_y, robot2_x, robot2_y, output ready);
endinterface

interface tpsf_fit_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] scale_cos;
    logic signed [W-1:0] scale_sin;
    logic signed [W-1:0] shift_x;
    logic signed [W-1:0] shift_y;
    logic                degenerate;
    logic                saturated;

    modport source (output valid, scale_cos, scale_sin, shift_x, shift_y,
                    degenerate, saturated, input ready);
    modport sink   (input valid, scale_cos, scale_sin, shift_x, shift_y,
                    degenerate, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/tpsf_div.sv
// tpsf_div: pipelined restoring divider, one quotient bit per stage
// depends on tpsf_pkg
`default_nettype none
module tpsf_div #(
    parameter int W = 32
) (
    input  wire logic                                 clk,
    input  wire logic [W:0]                           en,
    input  wire logic [tpsf_pkg::rem_w(W)-1:0]        mag,
    input  wire logic [tpsf_pkg::rem_w(W)-1:0]        den2,
    output logic      [W:0]                           q,
    output logic                                      ovf
);
    localparam int RW = tpsf_pkg::rem_w(W);
    localparam int QW = W + 1;

    logic [RW-1:0] r_reg [QW-1];
    logic [RW-1:0] d_reg [QW-1];
    logic [QW-1:0] q_reg [QW];
    logic          o_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [RW-1:0] r_i;
        logic [RW-1:0] d_i;
        logic [QW-1:0] q_i;
        logic          o_i;
        logic [RW-1:0] shd;
        logic          ge;

        if (j == 0) begin : g_first
            assign r_i = mag;
            assign d_i = den2;
            assign q_i = '0;
            // quotient would not fit in QW bits
            assign o_i = (mag >= (den2 << QW));
        end
        else begin : g_next
            assign r_i = r_reg[j-1];
            assign d_i = d_reg[j-1];
            assign q_i = q_reg[j-1];
            assign o_i = o_reg[j-1];
        end

        assign shd = d_i << (W - j);
        assign ge  = (r_i >= shd);

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                q_reg[j] <= q_i | (ge ? (QW'(1) << (W - j)) : QW'(0));
                o_reg[j] <= o_i;
            end
        end

        if (j < QW - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    r_reg[j] <= ge ? (r_i - shd) : r_i;
                    d_reg[j] <= d_i;
                end
            end
        end
    end

    assign q   = q_reg[QW-1];
    assign ovf = o_reg[QW-1];
endmodule
`default_nettype wire

// File: rtl/two_point_similarity_fit.sv
// two_point_similarity_fit: top level, pipelined fit of a 2D similarity transform
// depends on tpsf_pkg, tpsf_pts_if, tpsf_fit_if and tpsf_div
`default_nettype none
// Takes two user-frame points and the matching robot-frame points in one
// transfer and returns a = s*cos, b = s*sin and the shifts c, d in one transfer,
// all signed fixed point with FRAC_BITS fraction bits in COORD_WIDTH bits.
// The block is a pipeline of COORD_WIDTH+9 register stages (41 at the default
// width), and a new point set is taken in every cycle unless every stage holds
// data and the output is not ready. The depth is set by the two dividers that
// form a and b, which produce one quotient bit per stage. Stages whose valid
// bit is clear take new data even while the output waits, so bubbles close up
// under backpressure. Coincident user points give zeros and the degenerate flag.
module two_point_similarity_fit #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tpsf_pts_if.sink        pts,
    tpsf_fit_if.source      fit
);
    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = W + 1;                 // coordinate differences
    localparam int PW  = 2 * W + 2;             // difference products
    localparam int NW  = 2 * W + 3;             // numerator sums
    localparam int RW  = tpsf_pkg::rem_w(W);    // divider path
    localparam int QW  = W + 1;                 // quotient bits
    localparam int TW  = 2 * W + 1;             // shift product terms
    localparam int CW  = 2 * W + 3;             // shift before clipping
    // stage map
    localparam int S_DIFF = 0;
    localparam int S_MUL  = 1;
    localparam int S_SUM  = 2;
    localparam int S_PRE  = 3;
    localparam int S_DIV  = 4;
    localparam int S_AB   = S_DIV + QW;
    localparam int S_PM   = S_AB + 1;
    localparam int S_RND  = S_PM + 1;
    localparam int S_OUT  = S_RND + 1;
    localparam int NST    = S_OUT + 1;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                deg;
        logic                neg_a;
        logic                neg_b;
        logic signed [W-1:0] xv1;
        logic signed [W-1:0] yv1;
        logic signed [W-1:0] x1;
        logic signed [W-1:0] y1;
    } side_t;

    // clip a wide signed value to the coordinate range
    function automatic logic [W:0] clip(input logic signed [CW-1:0] v);
        logic [W:0] r;
        if (v > CW'(MAXV))
            r = {1'b1, MAXV};
        else if (v < CW'(MINV))
            r = {1'b1, MINV};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // handshake: a stage loads when it is empty or its successor loads
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !v_reg[NST-1] || fit.ready;
        for (int i = NST - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign pts.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= pts.valid;
            for (int i = 1; i < NST; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    side_t side_reg [NST-1];

    // stage 0: differences
    logic signed [DW-1:0] du_reg, dv_reg, dx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_DIFF])
        begin
            du_reg <= DW'(pts.user1_x) - DW'(pts.user2_x);
            dv_reg <= DW'(pts.user1_y) - DW'(pts.user2_y);
            dx_reg <= DW'(pts.robot1_x) - DW'(pts.robot2_x);
            dy_reg <= DW'(pts.robot1_y) - DW'(pts.robot2_y);
            side_reg[S_DIFF] <= '{deg: 1'b0, neg_a: 1'b0, neg_b: 1'b0,
                                  xv1: pts.user1_x, yv1: pts.user1_y,
                                  x1: pts.robot1_x, y1: pts.robot1_y};
        end
    end

    // stage 1: the six products
    logic signed [PW-1:0] puu_reg, pvv_reg, pxu_reg, pyv_reg, pyu_reg, pxv_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_MUL])
        begin
            puu_reg <= PW'(du_reg * du_reg);
            pvv_reg <= PW'(dv_reg * dv_reg);
            pxu_reg <= PW'(dx_reg * du_reg);
            pyv_reg <= PW'(dy_reg * dv_reg);
            pyu_reg <= PW'(dy_reg * du_reg);
            pxv_reg <= PW'(dx_reg * dv_reg);
            side_reg[S_MUL] <= side_reg[S_DIFF];
        end
    end

    // stage 2: shared squared distance and the two numerators
    logic signed [NW-1:0] den_s, na_s, nb_s;
    logic        [NW-1:0] den_reg, na_abs_reg, nb_abs_reg;
    side_t                sum_side;

    always_comb
    begin
        den_s = NW'(puu_reg) + NW'(pvv_reg);
        na_s  = NW'(pxu_reg) + NW'(pyv_reg);
        nb_s  = NW'(pyu_reg) - NW'(pxv_reg);
        sum_side       = side_reg[S_MUL];
        sum_side.deg   = (den_s == '0);
        sum_side.neg_a = na_s[NW-1];
        sum_side.neg_b = nb_s[NW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SUM])
        begin
            den_reg    <= den_s;
            na_abs_reg <= na_s[NW-1] ? -na_s : na_s;
            nb_abs_reg <= nb_s[NW-1] ? -nb_s : nb_s;
            side_reg[S_SUM] <= sum_side;
        end
    end

    // stage 3: rounding offset folded into the dividend
    logic [RW-1:0] mag_a_reg, mag_b_reg, den2_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_PRE])
        begin
            mag_a_reg <= (RW'(na_abs_reg) << (F + 1)) + RW'(den_reg);
            mag_b_reg <= (RW'(nb_abs_reg) << (F + 1)) + RW'(den_reg);
            den2_reg  <= RW'(den_reg) << 1;
            side_reg[S_PRE] <= side_reg[S_SUM];
        end
    end

    // dividers, one quotient bit per stage
    logic [QW-1:0] qa, qb;
    logic          ova, ovb;

    tpsf_div #(.W(W)) u_div_a (
        .clk  (clk),
        .en   (en[S_DIV +: QW]),
        .mag  (mag_a_reg),
        .den2 (den2_reg),
        .q    (qa),
        .ovf  (ova)
    );

    tpsf_div #(.W(W)) u_div_b (
        .clk  (clk),
        .en   (en[S_DIV +: QW]),
        .mag  (mag_b_reg),
        .den2 (den2_reg),
        .q    (qb),
        .ovf  (ovb)
    );

    for (genvar j = S_DIV; j < S_AB; j++) begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[j])
                side_reg[j] <= side_reg[j-1];
        end
    end

    // stage a/b: sign and clip of the quotients
    logic signed [W-1:0] a_reg, b_reg;
    logic                clip_ab_reg;
    logic signed [W-1:0] a_n, b_n;
    logic                ca, cb;
    side_t               ab_side;

    always_comb
    begin
        ab_side = side_reg[S_AB-1];
        if (!ab_side.neg_a)
        begin
            ca  = ova || qa[W] || qa[W-1];
            a_n = ca ? MAXV : qa[W-1:0];
        end
        else
        begin
            ca  = ova || qa[W] || (qa[W-1] && (|qa[W-2:0]));
            a_n = ca ? MINV : W'(-qa);
        end
        if (!ab_side.neg_b)
        begin
            cb  = ovb || qb[W] || qb[W-1];
            b_n = cb ? MAXV : qb[W-1:0];
        end
        else
        begin
            cb  = ovb || qb[W] || (qb[W-1] && (|qb[W-2:0]));
            b_n = cb ? MINV : W'(-qb);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_AB])
        begin
            a_reg       <= a_n;
            b_reg       <= b_n;
            clip_ab_reg <= ca || cb;
            side_reg[S_AB] <= ab_side;
        end
    end

    // stage: products of a and b with the first user point
    logic signed [2*W-1:0] pax_reg, pby_reg, pbx_reg, pay_reg;
    logic signed [W-1:0]   a_pm_reg, b_pm_reg;
    logic                  clip_pm_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_PM])
        begin
            pax_reg     <= a_reg * side_reg[S_AB].xv1;
            pby_reg     <= b_reg * side_reg[S_AB].yv1;
            pbx_reg     <= b_reg * side_reg[S_AB].xv1;
            pay_reg     <= a_reg * side_reg[S_AB].yv1;
            a_pm_reg    <= a_reg;
            b_pm_reg    <= b_reg;
            clip_pm_reg <= clip_ab_reg;
            side_reg[S_PM] <= side_reg[S_AB];
        end
    end

    // stage: combine and round off the fraction bits
    logic signed [TW-1:0] tc, td;
    logic        [TW-1:0] tc_abs, td_abs, rc_m, rd_m;
    logic signed [CW-1:0] rc_reg, rd_reg;
    logic signed [W-1:0]  a_rd_reg, b_rd_reg;
    logic                 clip_rd_reg;

    always_comb
    begin
        tc     = TW'(pax_reg) - TW'(pby_reg);
        td     = TW'(pbx_reg) + TW'(pay_reg);
        tc_abs = tc[TW-1] ? -tc : tc;
        td_abs = td[TW-1] ? -td : td;
        rc_m   = (tc_abs + (TW'(1) << (F - 1))) >> F;
        rd_m   = (td_abs + (TW'(1) << (F - 1))) >> F;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_RND])
        begin
            rc_reg      <= tc[TW-1] ? -CW'(rc_m) : CW'(rc_m);
            rd_reg      <= td[TW-1] ? -CW'(rd_m) : CW'(rd_m);
            a_rd_reg    <= a_pm_reg;
            b_rd_reg    <= b_pm_reg;
            clip_rd_reg <= clip_pm_reg;
            side_reg[S_RND] <= side_reg[S_PM];
        end
    end

    // output stage: shifts, clip, degenerate override
    logic [W:0]           cc, cd;
    logic signed [W-1:0]  a_o_reg, b_o_reg, c_o_reg, d_o_reg;
    logic                 deg_o_reg, sat_o_reg;

    always_comb
    begin
        cc = clip(CW'(side_reg[S_RND].x1) - rc_reg);
        cd = clip(CW'(side_reg[S_RND].y1) - rd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            if (side_reg[S_RND].deg)
            begin
                a_o_reg   <= '0;
                b_o_reg   <= '0;
                c_o_reg   <= '0;
                d_o_reg   <= '0;
                deg_o_reg <= 1'b1;
                sat_o_reg <= 1'b0;
            end
            else
            begin
                a_o_reg   <= a_rd_reg;
                b_o_reg   <= b_rd_reg;
                c_o_reg   <= cc[W-1:0];
                d_o_reg   <= cd[W-1:0];
                deg_o_reg <= 1'b0;
                sat_o_reg <= clip_rd_reg || cc[W] || cd[W];
            end
        end
    end

    assign fit.valid      = v_reg[S_OUT];
    assign fit.scale_cos  = a_o_reg;
    assign fit.scale_sin  = b_o_reg;
    assign fit.shift_x    = c_o_reg;
    assign fit.shift_y    = d_o_reg;
    assign fit.degenerate = deg_o_reg;
    assign fit.saturated  = sat_o_reg;
endmodule
`default_nettype wire

// File: dv/testbench.sv
// testbench: self-checking bench for two_point_similarity_fit
// depends on tpsf_pts_if, tpsf_fit_if and the top level of the fit

`default_nettype none

// one point set as offered on the input channel
typedef struct {
    logic signed [31:0] u1x, u1y, u2x, u2y;
    logic signed [31:0] r1x, r1y, r2x, r2y;
} point_set_t;

// one fitted transform as returned on the output channel
typedef struct {
    logic signed [31:0] sc, ss, tx, ty;
    logic               degen, clip;
} transform_t;

// keeps the transforms still owed by the block and checks each returned one
class fit_scoreboard;
    localparam int FRAC = 16;
    localparam logic signed [127:0] HI = 128'sd2147483647;
    localparam logic signed [127:0] LO = -128'sd2147483648;

    transform_t owed[$];
    int errors;
    int n_checked;
    int n_degen;
    int n_clip;

    function new();
        errors = 0;
        n_checked = 0;
        n_degen = 0;
        n_clip = 0;
    endfunction

    static function logic signed [127:0] mag(input logic signed [127:0] v);
        mag = (v < 0) ? -v : v;
    endfunction

    // num/den with FRAC fraction bits, nearest with ties away from zero
    static function logic signed [127:0] ratio(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
        logic signed [127:0] q;
        q = ((mag(num) <<< (FRAC + 1)) + den) / (den <<< 1);
        ratio = (num < 0) ? -q : q;
    endfunction

    // drop FRAC fraction bits, nearest with ties away from zero
    static function logic signed [127:0] drop_frac(input logic signed [127:0] t);
        logic signed [127:0] q;
        q = (mag(t) + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
        drop_frac = (t < 0) ? -q : q;
    endfunction

    static function logic signed [31:0] clamp(input logic signed [127:0] v,
                                              inout logic hit);
        if (v > HI) begin
            hit = 1'b1;
            clamp = 32'sh7fffffff;
        end else if (v < LO) begin
            hit = 1'b1;
            clamp = 32'sh80000000;
        end else begin
            clamp = v[31:0];
        end
    endfunction

    static function transform_t fit_of(input point_set_t p);
        logic signed [127:0] du, dv, dx, dy, den, sa, sb, ax, ay;
        transform_t r;
        logic hit;
        du = $signed(p.u1x) - $signed(p.u2x);
        dv = $signed(p.u1y) - $signed(p.u2y);
        dx = $signed(p.r1x) - $signed(p.r2x);
        dy = $signed(p.r1y) - $signed(p.r2y);
        den = du * du + dv * dv;
        r = '{sc: '0, ss: '0, tx: '0, ty: '0, degen: 1'b1, clip: 1'b0};
        if (den == 0)
            return r;
        hit = 1'b0;
        r.degen = 1'b0;
        r.sc = clamp(ratio(dx * du + dy * dv, den), hit);
        r.ss = clamp(ratio(dy * du - dx * dv, den), hit);
        // shifts use the already clipped scale terms
        sa = r.sc;
        sb = r.ss;
        ax = drop_frac(sa * $signed(p.u1x) - sb * $signed(p.u1y));
        ay = drop_frac(sb * $signed(p.u1x) + sa * $signed(p.u1y));
        r.tx = clamp($signed(p.r1x) - ax, hit);
        r.ty = clamp($signed(p.r1y) - ay, hit);
        r.clip = hit;
        return r;
    endfunction

    function void note_points(input point_set_t p);
        owed.push_back(fit_of(p));
    endfunction

    function void check_fit(input transform_t got);
        transform_t want;
        if (owed.size() == 0) begin
            errors++;
            $display("%0t: unexpected fit sc=%h ss=%h tx=%h ty=%h", $time,
                     got.sc, got.ss, got.tx, got.ty);
            return;
        end
        want = owed.pop_front();
        n_checked++;
        if (want.degen) n_degen++;
        if (want.clip) n_clip++;
        if (got.sc !== want.sc) begin
            errors++;
            $display("%0t: scale_cos expected %h actual %h", $time, want.sc, got.sc);
        end
        if (got.ss !== want.ss) begin
            errors++;
            $display("%0t: scale_sin expected %h actual %h", $time, want.ss, got.ss);
        end
        if (got.tx !== want.tx) begin
            errors++;
            $display("%0t: shift_x expected %h actual %h", $time, want.tx, got.tx);
        end
        if (got.ty !== want.ty) begin
            errors++;
            $display("%0t: shift_y expected %h actual %h", $time, want.ty, got.ty);
        end
        if (got.degen !== want.degen) begin
            errors++;
            $display("%0t: degenerate expected %b actual %b", $time,
                     want.degen, got.degen);
        end
        if (got.clip !== want.clip) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time,
                     want.clip, got.clip);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY   = 41;        // pipeline depth at the default width
    localparam int  LIMIT     = 400000;    // cycle budget for the whole run
    localparam int  N_PHASE   = 300;       // random items per idling phase
    localparam int  HOLD_AT   = 117;       // directed items plus a hundred random ones

    logic clk;
    logic rst_n;

    tpsf_pts_if #(.W(32)) pts_ch ();
    tpsf_fit_if #(.W(32)) fit_ch ();

    two_point_similarity_fit #(.FRAC_BITS(16), .COORD_WIDTH(32)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pts   (pts_ch),
        .fit   (fit_ch)
    );

    fit_scoreboard board;
    int send_gap_pct;     // chance of an idle cycle before each transfer
    int recv_stall_pct;   // chance that ready is low in a cycle
    int hold_left;        // cycles of forced backpressure still to go
    logic hold_done;      // the long hold-off has been started
    int cycles = 0;
    int n_sent;

    // free-running clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle budget; a hung handshake ends here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off once enough items went in
    always @(negedge clk) begin
        if (!rst_n) begin
            fit_ch.ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            fit_ch.ready <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            // long backpressure while the sender keeps offering
            hold_done <= 1'b1;
            hold_left <= 3 * LATENCY - 1;
            fit_ch.ready <= 1'b0;
        end else begin
            fit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // every output transfer goes to the scoreboard, sampled at the edge
    always @(posedge clk) begin
        if (rst_n && fit_ch.valid && fit_ch.ready)
            board.check_fit('{sc: fit_ch.scale_cos, ss: fit_ch.scale_sin,
                              tx: fit_ch.shift_x, ty: fit_ch.shift_y,
                              degen: fit_ch.degenerate, clip: fit_ch.saturated});
    end

    // offer one point set, keep it up until the transfer happens
    task automatic offer(input point_set_t p);
        while ($urandom_range(99) < send_gap_pct) begin
            pts_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pts_ch.valid    <= 1'b1;
        pts_ch.user1_x  <= p.u1x;
        pts_ch.user1_y  <= p.u1y;
        pts_ch.user2_x  <= p.u2x;
        pts_ch.user2_y  <= p.u2y;
        pts_ch.robot1_x <= p.r1x;
        pts_ch.robot1_y <= p.r1y;
        pts_ch.robot2_x <= p.r2x;
        pts_ch.robot2_y <= p.r2y;
        do
            @(posedge clk);
        while (!pts_ch.ready);
        board.note_points(p);
        n_sent++;
        // valid stays high; the next offer or the idle drop decides it
        @(negedge clk);
    endtask

    // no further input until the block has returned everything owed
    task automatic drain();
        pts_ch.valid <= 1'b0;
        while (board.owed.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_full();
        rand_full = $urandom();
    endfunction

    // moderate coordinate, from -2^24 to 2^24-1 (within +/-256 units at 16 fraction bits)
    function automatic logic signed [31:0] rand_mid();
        rand_mid = $signed($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000;
    endfunction

    // random point set; the mix leans on plausible calibrations
    function automatic point_set_t rand_points();
        point_set_t p;
        int kind;
        kind = $urandom_range(9);
        p = '{rand_mid(), rand_mid(), rand_mid(), rand_mid(),
              rand_mid(), rand_mid(), rand_mid(), rand_mid()};
        case (kind)
            0, 1: p = '{rand_full(), rand_full(), rand_full(), rand_full(),
                        rand_full(), rand_full(), rand_full(), rand_full()};
            2: begin
                // coincident user points
                p.u2x = p.u1x;
                p.u2y = p.u1y;
            end
            3: begin
                // nearly coincident user points push the scale out of range
                p.u2x = p.u1x + $signed(32'($urandom_range(6))) - 3;
                p.u2y = p.u1y + $signed(32'($urandom_range(6))) - 3;
            end
            4: begin
                // robot points coincide: zero scale
                p.r2x = p.r1x;
                p.r2y = p.r1y;
            end
            5: begin
                // mixed extremes on a few fields
                if ($urandom_range(1)) p.u1x = 32'sh80000000;
                if ($urandom_range(1)) p.r1y = 32'sh7fffffff;
                if ($urandom_range(1)) p.u2y = rand_full();
            end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        point_set_t d[$];
        logic signed [31:0] mx, mn, one;
        board = new();
        n_sent = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        pts_ch.valid = 1'b0;
        pts_ch.user1_x = '0;
        pts_ch.user1_y = '0;
        pts_ch.user2_x = '0;
        pts_ch.user2_y = '0;
        pts_ch.robot1_x = '0;
        pts_ch.robot1_y = '0;
        pts_ch.robot2_x = '0;
        pts_ch.robot2_y = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        one = 32'sh0001_0000;
        // directed: identity, rotations, degenerate, extremes, clipping, rounding
        d.push_back('{0, 0, one, 0, 0, 0, one, 0});
        d.push_back('{0, 0, one, 0, 0, 0, 0, one});
        d.push_back('{one, one, -one, -one, 5 * one, 7 * one, 3 * one, 2 * one});
        d.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
        d.push_back('{mx, mn, mx, mn, mx, mx, mn, mn});
        d.push_back('{mx, mx, mn, mn, mx, mx, mn, mn});
        d.push_back('{mn, mn, mx, mx, mx, mx, mn, mn});
        d.push_back('{mx, mn, mn, mx, mn, mx, mx, mn});
        d.push_back('{0, 0, 1, 0, mx, mx, mn, mn});
        d.push_back('{0, 0, 0, 1, mn, 0, mx, 0});
        d.push_back('{mx, mx, mx - 1, mx, 0, 0, 0, 0});
        d.push_back('{0, 0, 3, 0, 0, 0, 1, 0});
        d.push_back('{0, 0, 2, 0, 1, 0, 0, 0});
        d.push_back('{7, -3, 1, 5, 11, 2, -9, 4});
        d.push_back('{mx, 0, 0, 0, 0, mx, 0, 0});
        d.push_back('{32'shffffffff, 32'shffffffff, 0, 0, mx, mn, mn, mx});
        d.push_back('{32'sh5555aaaa, 32'shaaaa5555, 32'sh3333cccc, 32'shcccc3333,
                      32'sh0f0f0f0f, 32'shf0f0f0f0, 32'sh00ff00ff, 32'shff00ff00});
        foreach (d[i])
            offer(d[i]);

        // random phases: no idling, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct   = (ph == 1) ? 56 : (ph == 3) ? 28 : 0;
            recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 28 : 0;
            for (int k = 0; k < N_PHASE; k++) begin
                // sender pause until the pipeline has emptied
                if (k == 200)
                    drain();
                offer(rand_points());
            end
        end

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d point sets, checked %0d fits", n_sent, board.n_checked);
        $display("fits with coincident user points %0d, with clipping %0d",
                 board.n_degen, board.n_clip);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: two_point_similarity_fit.f
rtl/tpsf_pkg.sv
rtl/tpsf_if.sv
rtl/tpsf_div.sv
rtl/two_point_similarity_fit.sv
dv/testbench.sv
